/* hw/rtl/mls_pkg.sv */
// ----------------------------------------------------------------------------
// mls_pkg - shared types and constants for the matrix line sum block
// Sizes, widths and the structs that pass between the accumulator, the
// sorter and the sum list memory.
// ----------------------------------------------------------------------------
`default_nettype none

package mls_pkg;

    // Largest and smallest supported matrix size
    localparam int MAX_SIZE   = 16;
    localparam int MIN_SIZE   = 3;
    // Diagonals, rows and columns
    localparam int LIST_DEPTH = 2 * MAX_SIZE + 2;

    localparam int ELEM_W = 16;
    localparam int SUM_W  = 20;
    localparam int SIZE_W = 5;
    localparam int COL_W  = $clog2(MAX_SIZE);
    localparam int IDX_W  = $clog2(LIST_DEPTH);

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd4;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [SIZE_W-1:0]        t_size;
    typedef logic [COL_W-1:0]         t_col;
    typedef logic [IDX_W-1:0]         t_idx;

    // Write request into the sum list memory
    typedef struct packed {
        logic en;
        t_idx addr;
        t_sum data;
    } t_ram_wr;

    // Hand-off from accumulator to sorter
    typedef struct packed {
        logic go;
        t_idx count;
    } t_sort_start;

endpackage

`default_nettype wire

/* hw/rtl/mls_ram.sv */
// ----------------------------------------------------------------------------
// mls_ram - generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mls_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 34
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/mls_accum.sv */
// ----------------------------------------------------------------------------
// mls_accum - running line sums and sum list fill
// Keeps diagonal, row and column totals as elements arrive, writes each row
// sum at end of row, then copies diagonals and columns into the sum list.
// ----------------------------------------------------------------------------
`default_nettype none

module mls_accum (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [4:0]             i_cfg_data,
    input  wire                   i_take,
    input  mls_pkg::t_elem        i_value,
    output mls_pkg::t_ram_wr      o_wr,
    output mls_pkg::t_sort_start  o_start,
    output logic                  o_busy
);

    logic                 r_copy;
    mls_pkg::t_size       r_size;
    mls_pkg::t_size       r_k;
    mls_pkg::t_col        r_r;
    mls_pkg::t_col        r_c;
    mls_pkg::t_sum        r_col [mls_pkg::MAX_SIZE];
    mls_pkg::t_sum        r_row;
    mls_pkg::t_sum        r_main;
    mls_pkg::t_sum        r_anti;

    mls_pkg::t_size       eff_size;
    mls_pkg::t_sum        v20;
    mls_pkg::t_sum        col_new;
    mls_pkg::t_sum        row_new;
    logic                 last_col;
    logic                 last_row;
    logic                 on_main;
    logic                 on_anti;
    logic                 copy_end;
    mls_pkg::t_col        copy_col;

    // Clamp the size register to the supported range
    always_comb begin
        if (r_size < mls_pkg::t_size'(mls_pkg::MIN_SIZE)) begin
            eff_size = mls_pkg::t_size'(mls_pkg::MIN_SIZE);
        end else if (r_size > mls_pkg::t_size'(mls_pkg::MAX_SIZE)) begin
            eff_size = mls_pkg::t_size'(mls_pkg::MAX_SIZE);
        end else begin
            eff_size = r_size;
        end
    end

    // Element arithmetic, all sums wrap at 20 bits
    assign v20      = mls_pkg::t_sum'(i_value);
    assign col_new  = r_col[r_c] + v20;
    assign row_new  = r_row + v20;
    assign last_col = ({1'b0, r_c} + 5'd1) == eff_size;
    assign last_row = ({1'b0, r_r} + 5'd1) == eff_size;
    assign on_main  = r_r == r_c;
    assign on_anti  = ({1'b0, r_r} + {1'b0, r_c}) == (eff_size - 5'd1);

    // Copy step k: 0 main diagonal, 1 anti-diagonal, then column k-2
    assign copy_col = mls_pkg::t_col'(r_k - 5'd2);
    assign copy_end = r_k == (eff_size + 5'd1);

    // Sum list write port
    always_comb begin
        o_wr.en   = 1'b0;
        o_wr.addr = mls_pkg::t_idx'(r_r) + mls_pkg::t_idx'(2);
        o_wr.data = row_new;
        if (r_copy) begin
            o_wr.en   = 1'b1;
            o_wr.addr = mls_pkg::t_idx'(eff_size) + mls_pkg::t_idx'(r_k);
            if (r_k == 5'd0) begin
                o_wr.addr = mls_pkg::t_idx'(0);
                o_wr.data = r_main;
            end else if (r_k == 5'd1) begin
                o_wr.addr = mls_pkg::t_idx'(1);
                o_wr.data = r_anti;
            end else begin
                o_wr.data = r_col[copy_col];
            end
        end else if (i_take && last_col) begin
            o_wr.en = 1'b1;
        end
    end

    assign o_start.go    = r_copy && copy_end;
    assign o_start.count = mls_pkg::t_idx'(eff_size) + mls_pkg::t_idx'(eff_size)
                         + mls_pkg::t_idx'(2);
    assign o_busy        = r_copy;

    // Totals, positions and copy sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (r_copy && copy_end)) begin
            for (int j = 0; j < mls_pkg::MAX_SIZE; j++) begin
                r_col[j] <= '0;
            end
            r_row  <= '0;
            r_main <= '0;
            r_anti <= '0;
            r_r    <= '0;
            r_c    <= '0;
            r_copy <= 1'b0;
            r_k    <= '0;
            if (!i_rst_n) begin
                r_size <= mls_pkg::SIZE_RESET;
            end else if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
        end else if (r_copy) begin
            r_k <= r_k + 5'd1;
        end else if (i_take) begin
            r_col[r_c] <= col_new;
            if (on_main) begin
                r_main <= r_main + v20;
            end
            if (on_anti) begin
                r_anti <= r_anti + v20;
            end
            if (last_col) begin
                r_row <= '0;
                r_c   <= '0;
                if (last_row) begin
                    r_r    <= '0;
                    r_copy <= 1'b1;
                    r_k    <= '0;
                end else begin
                    r_r <= r_r + mls_pkg::t_col'(1);
                end
            end else begin
                r_row <= row_new;
                r_c   <= r_c + mls_pkg::t_col'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mls_sort.sv */
// ----------------------------------------------------------------------------
// mls_sort - selection sorter over the sum list memory
// Each pass scans the list through one compare unit, finds the largest
// entry not yet sent, and holds it in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mls_sort (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mls_pkg::t_sort_start  i_start,
    input  mls_pkg::t_sum         i_rd_data,
    output mls_pkg::t_idx         o_rd_addr,
    output logic                  o_busy,
    output logic                  o_valid,
    input  wire                   i_stall,
    output mls_pkg::t_sum         o_sum,
    output logic                  o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    mls_pkg::t_idx                    r_count;
    mls_pkg::t_idx                    r_sent;
    mls_pkg::t_idx                    r_scan;
    logic                             r_issue;
    logic                             r_dv;
    mls_pkg::t_idx                    r_didx;
    logic                             r_have;
    mls_pkg::t_sum                    r_best;
    mls_pkg::t_idx                    r_best_idx;
    logic [mls_pkg::LIST_DEPTH-1:0]   r_used;

    logic better;
    logic scan_done;
    logic beat_out;
    logic last_beat;

    assign o_rd_addr = r_scan;
    assign o_busy    = r_state != S_IDLE;
    assign o_valid   = r_state == S_EMIT;
    assign o_sum     = r_best;
    assign last_beat = r_sent == (r_count - mls_pkg::t_idx'(1));
    assign o_last    = last_beat;
    assign beat_out  = o_valid && !i_stall;

    // Shared compare: take the entry if unsent and larger than the best so far
    assign better    = r_dv && !r_used[r_didx] && (!r_have || (i_rd_data > r_best));
    assign scan_done = !r_issue && r_dv;

    // Pass sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start.go) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (beat_out) begin
                    n_state = last_beat ? S_IDLE : S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_have  <= 1'b0;
            r_used  <= '0;
            r_sent  <= '0;
            r_scan  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_count <= i_start.count;
                    r_sent  <= '0;
                    r_used  <= '0;
                    r_scan  <= '0;
                    r_issue <= 1'b1;
                    r_dv    <= 1'b0;
                    r_have  <= 1'b0;
                end
                S_SCAN: begin
                    // Address issue, data returns in the next cycle
                    r_dv   <= r_issue;
                    r_didx <= r_scan;
                    if (r_issue) begin
                        if (r_scan == (r_count - mls_pkg::t_idx'(1))) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_scan <= r_scan + mls_pkg::t_idx'(1);
                        end
                    end
                    if (better) begin
                        r_have     <= 1'b1;
                        r_best     <= i_rd_data;
                        r_best_idx <= r_didx;
                    end
                end
                S_EMIT: begin
                    if (beat_out) begin
                        r_used[r_best_idx] <= 1'b1;
                        r_sent  <= r_sent + mls_pkg::t_idx'(1);
                        r_scan  <= '0;
                        r_issue <= 1'b1;
                        r_dv    <= 1'b0;
                        r_have  <= 1'b0;
                    end
                end
                default: r_issue <= 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/matrix_line_sums_sorted.sv */
// ----------------------------------------------------------------------------
// matrix_line_sums_sorted - sorted diagonal, row and column sums of a matrix
// Takes an n-by-n matrix in row-major order and returns its 2n+2 line sums
// from largest to smallest, the final one marked.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while a matrix fills (n*n elements). After
// the last element the block stalls its input: copy steps write the diagonal
// and column totals into the sum list memory, then each of the 2n+2 sums
// costs one scan of that memory through a single compare unit, followed by
// its beat, shown until taken. For larger n the sort scans take most of the
// time of a matrix. Size writes are to be made by the user between matrices,
// which the block itself does not enforce, and discard any partial matrix;
// sizes below 3 act as 3 and above 16 as 16.
`default_nettype none

module matrix_line_sums_sorted (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [4:0]            i_cfg_data,
    input  wire                  i_elem_valid,
    output logic                 o_elem_stall,
    input  wire signed [15:0]    i_element_value,
    output logic                 o_sum_valid,
    input  wire                  i_sum_stall,
    output logic signed [19:0]   o_line_sum,
    output logic                 o_last_sum
);

    mls_pkg::t_ram_wr      wr;
    mls_pkg::t_sort_start  start;
    mls_pkg::t_idx         rd_addr;
    logic [mls_pkg::SUM_W-1:0] rd_data;
    logic                  acc_busy;
    logic                  sort_busy;
    logic                  take;

    // Input beat taken only while filling
    assign o_elem_stall = acc_busy || sort_busy;
    assign take         = i_elem_valid && !o_elem_stall;

    mls_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_value    (i_element_value),
        .o_wr       (wr),
        .o_start    (start),
        .o_busy     (acc_busy)
    );

    mls_ram #(
        .WIDTH (mls_pkg::SUM_W),
        .DEPTH (mls_pkg::LIST_DEPTH)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    mls_sort u_sort (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_rd_data (mls_pkg::t_sum'(rd_data)),
        .o_rd_addr (rd_addr),
        .o_busy    (sort_busy),
        .o_valid   (o_sum_valid),
        .i_stall   (i_sum_stall),
        .o_sum     (o_line_sum),
        .o_last    (o_last_sum)
    );

endmodule

`default_nettype wire

/* hw/rtl/mls_checker.sv */
// ----------------------------------------------------------------------------
// mls_checker - port-level checks for matrix_line_sums_sorted
// Watches the ports for ordering of sums and separation of fill and output.
// ----------------------------------------------------------------------------
`default_nettype none

module mls_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_elem_valid,
    input  wire                 o_elem_stall,
    input  wire                 o_sum_valid,
    input  wire                 i_sum_stall,
    input  wire signed [19:0]   o_line_sum,
    input  wire                 o_last_sum
);

    logic                r_mid;
    logic signed [19:0]  r_prev;
    logic                out_beat;

    assign out_beat = o_sum_valid && !i_sum_stall;

    // Track whether a matrix's sums are partly sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (out_beat) begin
            r_mid  <= !o_last_sum;
            r_prev <= o_line_sum;
        end
    end

    // Sums of one matrix never increase
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && r_mid) |-> (o_line_sum <= r_prev))
        else $error("line sums out of order");

    // No element is taken while a sum waits
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sum_valid |-> o_elem_stall)
        else $error("input open while a sum is pending");

    // No element is taken between sums of one matrix
    a_mid_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> !(i_elem_valid && !o_elem_stall))
        else $error("element taken in the middle of a sum list");

    // Reset leaves no sum pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_sum_valid)
        else $error("sum valid after reset");

endmodule

bind matrix_line_sums_sorted mls_checker u_chk (.*);

`default_nettype wire
